// ===== hdl/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types, constants and helpers for the circular stack ALU.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 8;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int OPCODE_W    = 5;
  localparam int KIND_W      = 2;
  localparam int HEX_W       = 16;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STACK_DEPTH - 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_NOP     = 5'd0,
    OP_PUSH    = 5'd1,
    OP_DUP     = 5'd2,
    OP_DROP    = 5'd3,
    OP_BACK    = 5'd4,
    OP_SWAP    = 5'd5,
    OP_OVER    = 5'd6,
    OP_ADD     = 5'd7,
    OP_AND     = 5'd8,
    OP_OR      = 5'd9,
    OP_XOR     = 5'd10,
    OP_INVERT  = 5'd11,
    OP_NEGATE  = 5'd12,
    OP_DOT     = 5'd13,
    OP_DOTHEX  = 5'd14,
    OP_DOTS    = 5'd15,
    OP_DOTSHEX = 5'd16,
    OP_SPEED   = 5'd17,
    OP_DELAY   = 5'd18
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEC   = 2'd0,
    KIND_HEX   = 2'd1,
    KIND_DELAY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWAP2,
    ST_DUMP_RD,
    ST_DUMP_EMIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             re;
    logic [PTR_W-1:0] addr0;
    logic [PTR_W-1:0] addr1;
  } ram_rd_t;

  // hex display keeps only the low half-word
  function automatic logic [DATA_W-1:0] fmt_value(kind_t kind, logic [DATA_W-1:0] word);
    logic [DATA_W-1:0] res;
    res = word;
    if (kind == KIND_HEX) begin
      res = {{(DATA_W-HEX_W){1'b0}}, word[HEX_W-1:0]};
    end
    return res;
  endfunction

endpackage

// ===== hdl/csa_stack_ram.sv =====
// ----------------------------------------------------------------------------
// csa_stack_ram
// Stack store: one write port, two registered read ports, entries read as
// zero until first written.
// ----------------------------------------------------------------------------
module csa_stack_ram
  import csa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ram_wr_t           wr,
  input  ram_rd_t           rd,
  output logic [DATA_W-1:0] rd_data0,
  output logic [DATA_W-1:0] rd_data1
);

  logic [DATA_W-1:0]      mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] valid_r;
  logic [DATA_W-1:0]      rd0_r;
  logic [DATA_W-1:0]      rd1_r;
  logic                   vld0_r;
  logic                   vld1_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd0_r  <= mem[rd.addr0];
      rd1_r  <= mem[rd.addr1];
      vld0_r <= valid_r[rd.addr0];
      vld1_r <= valid_r[rd.addr1];
    end
  end

  assign rd_data0 = vld0_r ? rd0_r : '0;
  assign rd_data1 = vld1_r ? rd1_r : '0;

endmodule

// ===== hdl/circular_stack_alu.sv =====
// ----------------------------------------------------------------------------
// circular_stack_alu
// Forth-style circular data stack with a small ALU and display output.
// ----------------------------------------------------------------------------
// One request is worked on at a time. The stack lives in a synchronous
// memory with a registered read, so most opcodes pass through an accept and
// read state, then a modify and write-back state; swap adds a second write
// state since the memory has a single write port. Single-result opcodes also
// wait for the output register to be free. Whole-stack display does one read
// and one emit per entry and waits on output stalls. A finished result sits
// in the output register while the next request is accepted. The speed
// opcode only pops; the stored speed has no effect at the ports.
module circular_stack_alu
  import csa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPCODE_W-1:0]      in_opcode,
  input  logic signed [DATA_W-1:0] in_literal,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KIND_W-1:0]        out_kind,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last
);

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    sp_r, sp_nxt;
  logic [PTR_W-1:0]    cnt_r, cnt_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [DATA_W-1:0]   lit_r, lit_nxt;
  logic [DATA_W-1:0]   tmp_r, tmp_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  ram_wr_t             wr;
  ram_rd_t             rd;
  logic [DATA_W-1:0]   rd0;
  logic [DATA_W-1:0]   rd1;
  logic                out_free;
  logic                out_load;
  kind_t               emit_kind;
  logic [PTR_W-1:0]    sp_up;
  logic [PTR_W-1:0]    sp_dn;

  csa_stack_ram u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd       (rd),
    .rd_data0 (rd0),
    .rd_data1 (rd1)
  );

  assign out_free = !out_valid_r || out_ready;
  assign sp_up    = sp_r + PTR_W'(1);
  assign sp_dn    = sp_r - PTR_W'(1);

  always_comb begin
    case (op_r)
      OP_DOTHEX, OP_DOTSHEX: emit_kind = KIND_HEX;
      OP_DELAY:              emit_kind = KIND_DELAY;
      default:               emit_kind = KIND_DEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    lit_r       <= lit_nxt;
    tmp_r       <= tmp_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    lit_nxt       = lit_r;
    tmp_nxt       = tmp_r;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    wr            = '0;
    rd            = '0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_opcode;
          lit_nxt   = in_literal;
          rd.re     = 1'b1;
          rd.addr0  = sp_r;
          rd.addr1  = sp_dn;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (op_r)
          OP_PUSH: begin
            wr     = '{we: 1'b1, addr: sp_up, data: lit_r};
            sp_nxt = sp_up;
          end
          OP_DUP: begin
            wr     = '{we: 1'b1, addr: sp_up, data: rd0};
            sp_nxt = sp_up;
          end
          OP_DROP, OP_SPEED: sp_nxt = sp_dn;
          OP_BACK:           sp_nxt = sp_up;
          OP_SWAP: begin
            wr        = '{we: 1'b1, addr: sp_r, data: rd1};
            tmp_nxt   = rd0;
            state_nxt = ST_SWAP2;
          end
          OP_OVER: begin
            wr     = '{we: 1'b1, addr: sp_up, data: rd1};
            sp_nxt = sp_up;
          end
          OP_ADD: begin
            wr     = '{we: 1'b1, addr: sp_dn, data: rd0 + rd1};
            sp_nxt = sp_dn;
          end
          OP_AND: begin
            wr     = '{we: 1'b1, addr: sp_dn, data: rd0 & rd1};
            sp_nxt = sp_dn;
          end
          OP_OR: begin
            wr     = '{we: 1'b1, addr: sp_dn, data: rd0 | rd1};
            sp_nxt = sp_dn;
          end
          OP_XOR: begin
            wr     = '{we: 1'b1, addr: sp_dn, data: rd0 ^ rd1};
            sp_nxt = sp_dn;
          end
          OP_INVERT: wr = '{we: 1'b1, addr: sp_r, data: ~rd0};
          OP_NEGATE: wr = '{we: 1'b1, addr: sp_r, data: DATA_W'(0) - rd0};
          OP_DOT, OP_DOTHEX, OP_DELAY: begin
            if (out_free) begin
              out_load      = 1'b1;
              out_kind_nxt  = emit_kind;
              out_value_nxt = fmt_value(emit_kind, rd0);
              out_last_nxt  = 1'b1;
              sp_nxt        = sp_dn;
            end else begin
              state_nxt = ST_EXEC;
            end
          end
          OP_DOTS, OP_DOTSHEX: begin
            // top entry is already read, emit it then walk down the rest
            if (out_free) begin
              out_load      = 1'b1;
              out_kind_nxt  = emit_kind;
              out_value_nxt = fmt_value(emit_kind, rd0);
              out_last_nxt  = 1'b0;
              cnt_nxt       = PTR_W'(1);
              state_nxt     = ST_DUMP_RD;
            end else begin
              state_nxt = ST_EXEC;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_SWAP2: begin
        wr        = '{we: 1'b1, addr: sp_dn, data: tmp_r};
        state_nxt = ST_IDLE;
      end

      ST_DUMP_RD: begin
        rd.re     = 1'b1;
        rd.addr0  = sp_r - cnt_r;
        rd.addr1  = sp_r - cnt_r;
        state_nxt = ST_DUMP_EMIT;
      end

      ST_DUMP_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = emit_kind;
          out_value_nxt = fmt_value(emit_kind, rd0);
          out_last_nxt  = (cnt_r == PTR_LAST);
          if (cnt_r == PTR_LAST) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + PTR_W'(1);
            state_nxt = ST_DUMP_RD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_dump_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP_RD || state_r == ST_DUMP_EMIT) |=> sp_r == $past(sp_r))
    else $error("stack pointer moved during whole-stack display");

  a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_EXEC || state_r == ST_SWAP2) |-> cnt_r == '0)
    else $error("dump counter not cleared outside display");

  a_swap_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWAP2 |-> $past(state_r) == ST_EXEC && op_r == OP_SWAP)
    else $error("second swap write without a swap");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds opcode requests to circular_stack_alu: a directed table, then random
// requests. Each display and delay result is checked against a behavioral
// model of the circular stack, or against the value a typed table row gives.
// Both sides stall at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench
  import csa_pkg::*;
();

  localparam int RANDOM_REQUESTS = 342;
  localparam int DIRECTED_ROWS   = 28;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 64;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_AFTER      = 250;

  localparam logic [OPCODE_W-1:0] OP_UNDEF_MAX = 5'd31;
  localparam logic [DATA_W-1:0]   SPEED_RESET  = 32'd15;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic              last;
  } disp_result_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [DATA_W-1:0]   lit;
    logic                typed;
    logic [KIND_W-1:0]   kind;
    logic [DATA_W-1:0]   value;
  } stack_req_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OPCODE_W-1:0]      in_opcode;
  logic signed [DATA_W-1:0] in_literal;
  logic                     out_valid;
  logic                     out_ready;
  logic [KIND_W-1:0]        out_kind;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  // model of the circular stack
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [PTR_W-1:0]  top_ptr;
  logic [DATA_W-1:0] speed_reg;

  disp_result_t pending_results[$];
  disp_result_t step_results[$];
  stack_req_t   directed_tab [DIRECTED_ROWS];

  int   error_count = 0;
  int   sent_count  = 0;
  logic no_idle;

  // stretch of requests where neither side idles
  assign no_idle = (sent_count >= 120) && (sent_count < 200);

  circular_stack_alu u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_literal(in_literal),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic void push_word(input logic [DATA_W-1:0] v);
    top_ptr = top_ptr + 1'b1;
    stack_mem[top_ptr] = v;
  endfunction

  function automatic logic [DATA_W-1:0] pop_word();
    logic [DATA_W-1:0] v;
    v = stack_mem[top_ptr];
    top_ptr = top_ptr - 1'b1;
    return v;
  endfunction

  function automatic void emit_result(input logic [KIND_W-1:0] kind,
                                      input logic [DATA_W-1:0] v);
    disp_result_t r;
    r.kind  = kind;
    r.value = (kind == KIND_HEX) ? {{(DATA_W-HEX_W){1'b0}}, v[HEX_W-1:0]} : v;
    r.last  = 1'b0;
    step_results.push_back(r);
  endfunction

  // applies one opcode to the model and leaves its results in step_results
  task automatic run_stack_op(input logic [OPCODE_W-1:0] op,
                              input logic [DATA_W-1:0] lit);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    disp_result_t      r;
    int                i;
    int                n;
    step_results.delete();
    case (op)
      OP_PUSH:   push_word(lit);
      OP_DUP:    push_word(stack_mem[top_ptr]);
      OP_DROP:   top_ptr = top_ptr - 1'b1;
      OP_BACK:   top_ptr = top_ptr + 1'b1;
      OP_SWAP: begin
        a = pop_word();
        b = pop_word();
        push_word(a);
        push_word(b);
      end
      OP_OVER: begin
        a = pop_word();
        b = pop_word();
        push_word(b);
        push_word(a);
        push_word(b);
      end
      OP_ADD: begin
        a = pop_word();
        stack_mem[top_ptr] = stack_mem[top_ptr] + a;
      end
      OP_AND: begin
        a = pop_word();
        stack_mem[top_ptr] = stack_mem[top_ptr] & a;
      end
      OP_OR: begin
        a = pop_word();
        stack_mem[top_ptr] = stack_mem[top_ptr] | a;
      end
      OP_XOR: begin
        a = pop_word();
        stack_mem[top_ptr] = stack_mem[top_ptr] ^ a;
      end
      OP_INVERT: stack_mem[top_ptr] = ~stack_mem[top_ptr];
      OP_NEGATE: stack_mem[top_ptr] = -stack_mem[top_ptr];
      OP_DOT:    emit_result(KIND_DEC, pop_word());
      OP_DOTHEX: emit_result(KIND_HEX, pop_word());
      OP_DOTS, OP_DOTSHEX: begin
        for (i = 0; i < STACK_DEPTH; i++) begin
          emit_result((op == OP_DOTS) ? KIND_DEC : KIND_HEX, pop_word());
        end
      end
      OP_SPEED:  speed_reg = pop_word();
      OP_DELAY:  emit_result(KIND_DELAY, pop_word());
      default: ;
    endcase
    // mark the final result of this request
    n = step_results.size();
    for (i = 0; i < n; i++) begin
      r = step_results.pop_front();
      r.last = (i == n - 1);
      step_results.push_back(r);
    end
  endtask

  task automatic send_request(input stack_req_t req);
    int           gap;
    disp_result_t typed_res;
    if (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= req.op;
    in_literal <= req.lit;
    do @(posedge clk); while (!in_ready);
    run_stack_op(req.op, req.lit);
    if (req.typed) begin
      typed_res.kind  = req.kind;
      typed_res.value = req.value;
      typed_res.last  = 1'b1;
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    sent_count++;
  endtask

  initial begin : stimulus
    stack_req_t req;
    int         i;
    int         r;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_opcode  <= OP_NOP;
    in_literal <= '0;

    // op, literal, typed, kind, value
    directed_tab[0]  = '{OP_NOP,     32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[1]  = '{OP_DOT,     32'h0000_0000, 1'b1, KIND_DEC,   32'h0};
    directed_tab[2]  = '{OP_DOTHEX,  32'h0000_0000, 1'b1, KIND_HEX,   32'h0};
    directed_tab[3]  = '{OP_DELAY,   32'h0000_0000, 1'b1, KIND_DELAY, 32'h0};
    directed_tab[4]  = '{OP_PUSH,    32'h7fff_ffff, 1'b0, KIND_DEC,   32'h0};
    directed_tab[5]  = '{OP_DOT,     32'h0000_0000, 1'b1, KIND_DEC,   32'h7fff_ffff};
    directed_tab[6]  = '{OP_PUSH,    32'hffff_ffff, 1'b0, KIND_DEC,   32'h0};
    directed_tab[7]  = '{OP_DOTHEX,  32'h0000_0000, 1'b1, KIND_HEX,   32'h0000_ffff};
    directed_tab[8]  = '{OP_PUSH,    32'h8000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[9]  = '{OP_DUP,     32'hffff_ffff, 1'b0, KIND_DEC,   32'h0};
    // min plus min wraps to zero
    directed_tab[10] = '{OP_ADD,     32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[11] = '{OP_DOT,     32'h0000_0000, 1'b1, KIND_DEC,   32'h0};
    directed_tab[12] = '{OP_PUSH,    32'h1234_5678, 1'b0, KIND_DEC,   32'h0};
    directed_tab[13] = '{OP_PUSH,    32'h8000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[14] = '{OP_OVER,    32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[15] = '{OP_SWAP,    32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[16] = '{OP_AND,     32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[17] = '{OP_OR,      32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[18] = '{OP_XOR,     32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[19] = '{OP_INVERT,  32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[20] = '{OP_NEGATE,  32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[21] = '{OP_DROP,    32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[22] = '{OP_BACK,    32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[23] = '{OP_SPEED,   32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    // undefined opcode behaves as nop
    directed_tab[24] = '{OP_UNDEF_MAX, 32'hdead_beef, 1'b0, KIND_DEC, 32'h0};
    directed_tab[25] = '{OP_DOTS,    32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[26] = '{OP_DOTSHEX, 32'h0000_0000, 1'b0, KIND_DEC,   32'h0};
    directed_tab[27] = '{OP_DELAY,   32'h0000_0000, 1'b0, KIND_DEC,   32'h0};

    for (i = 0; i < STACK_DEPTH; i++) stack_mem[i] = '0;
    top_ptr   = '0;
    speed_reg = SPEED_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) send_request(directed_tab[i]);

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        req.op = OPCODE_W'($urandom_range(int'(OP_DELAY) + 1, int'(OP_UNDEF_MAX)));
      end else if (r < 12) begin
        req.op = ($urandom_range(1) != 0) ? OP_DOTS : OP_DOTSHEX;
      end else if (r < 35) begin
        req.op = OP_PUSH;
      end else begin
        req.op = OPCODE_W'($urandom_range(int'(OP_DELAY)));
      end
      case ($urandom_range(9))
        0:       req.lit = 32'h8000_0000;
        1:       req.lit = 32'h7fff_ffff;
        2:       req.lit = '1;
        3:       req.lit = '0;
        default: req.lit = $urandom();
      endcase
      req.typed = 1'b0;
      req.kind  = KIND_DEC;
      req.value = '0;
      send_request(req);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      // one long hold-off so the output backs up into the input
      if (!held && sent_count >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= no_idle || ($urandom_range(99) >= 15);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    disp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %h last %b",
                                  out_kind, out_value, out_last));
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) begin
          report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        end
        if (out_value !== want.value) begin
          report_mismatch($sformatf("value %h, want %h", out_value, want.value));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %b, want %b", out_last, want.last));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t watchdog: no request or result moved for %0d cycles",
             $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== circular_stack_alu.f =====
hdl/csa_pkg.sv
hdl/csa_stack_ram.sv
hdl/circular_stack_alu.sv
tb/sv/testbench.sv
